[rtl/rvdec_pkg.sv]
package rvdec_pkg;

   localparam int unsigned INSTR_W = 32;
   localparam int unsigned OP_W    = 5;
   localparam int unsigned REG_W   = 5;
   localparam int unsigned IMM_W   = 32;
   localparam int unsigned RSP_W   = 56;

   localparam logic [6:0] OPC_BRANCH = 7'b1100011;
   localparam logic [6:0] OPC_LOAD   = 7'b0000011;
   localparam logic [6:0] OPC_STORE  = 7'b0100011;
   localparam logic [6:0] OPC_ALUI   = 7'b0010011;
   localparam logic [6:0] OPC_ALUR   = 7'b0110011;
   localparam logic [6:0] OPC_LUI    = 7'b0110111;
   localparam logic [6:0] OPC_JAL    = 7'b1101111;
   localparam logic [6:0] OPC_JALR   = 7'b1100111;
   localparam logic [6:0] OPC_NOP    = 7'b1111111;
   localparam logic [6:0] OPC_FLOAT  = 7'b1010011;

   localparam logic [OP_W-1:0] OP_BEQ     = 5'd0;
   localparam logic [OP_W-1:0] OP_BNE     = 5'd1;
   localparam logic [OP_W-1:0] OP_BLT     = 5'd2;
   localparam logic [OP_W-1:0] OP_BGE     = 5'd3;
   localparam logic [OP_W-1:0] OP_LW      = 5'd4;
   localparam logic [OP_W-1:0] OP_SW      = 5'd5;
   localparam logic [OP_W-1:0] OP_ADDI    = 5'd6;
   localparam logic [OP_W-1:0] OP_SLLI    = 5'd7;
   localparam logic [OP_W-1:0] OP_SRLI    = 5'd8;
   localparam logic [OP_W-1:0] OP_ADD     = 5'd9;
   localparam logic [OP_W-1:0] OP_SUB     = 5'd10;
   localparam logic [OP_W-1:0] OP_SLL     = 5'd11;
   localparam logic [OP_W-1:0] OP_LUI     = 5'd12;
   localparam logic [OP_W-1:0] OP_JAL     = 5'd13;
   localparam logic [OP_W-1:0] OP_JALR    = 5'd14;
   localparam logic [OP_W-1:0] OP_FADD    = 5'd15;
   localparam logic [OP_W-1:0] OP_FSUB    = 5'd16;
   localparam logic [OP_W-1:0] OP_FMUL    = 5'd17;
   localparam logic [OP_W-1:0] OP_FDIV    = 5'd18;
   localparam logic [OP_W-1:0] OP_FHALF   = 5'd19;
   localparam logic [OP_W-1:0] OP_SQRT    = 5'd20;
   localparam logic [OP_W-1:0] OP_FABS    = 5'd21;
   localparam logic [OP_W-1:0] OP_FNEG    = 5'd22;
   localparam logic [OP_W-1:0] OP_FISZERO = 5'd23;
   localparam logic [OP_W-1:0] OP_FISNEG  = 5'd24;
   localparam logic [OP_W-1:0] OP_FISPOS  = 5'd25;
   localparam logic [OP_W-1:0] OP_FLESS   = 5'd26;
   localparam logic [OP_W-1:0] OP_FLOOR   = 5'd27;
   localparam logic [OP_W-1:0] OP_FTOI    = 5'd28;
   localparam logic [OP_W-1:0] OP_ITOF    = 5'd29;
   localparam logic [OP_W-1:0] OP_NOP     = 5'd30;

   // funct3
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd4;
   localparam logic [2:0] F3_BLT  = 3'd1;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_WORD = 3'd2;
   localparam logic [2:0] F3_ADDI = 3'd0;
   localparam logic [2:0] F3_SLLI = 3'd1;
   localparam logic [2:0] F3_SRLI = 3'd5;
   localparam logic [2:0] F3_JALR = 3'd0;

   // {funct7, funct3}
   localparam logic [9:0] F10_ADD     = 10'h000;
   localparam logic [9:0] F10_SUB     = 10'h100;
   localparam logic [9:0] F10_SLL     = 10'h001;
   localparam logic [9:0] F10_FADD    = 10'h000;
   localparam logic [9:0] F10_FSUB    = 10'h020;
   localparam logic [9:0] F10_FMUL    = 10'h040;
   localparam logic [9:0] F10_FDIV    = 10'h060;
   localparam logic [9:0] F10_FHALF   = 10'h041;
   localparam logic [9:0] F10_SQRT    = 10'h160;
   localparam logic [9:0] F10_FABS    = 10'h082;
   localparam logic [9:0] F10_FNEG    = 10'h081;
   localparam logic [9:0] F10_FISZERO = 10'h282;
   localparam logic [9:0] F10_FISNEG  = 10'h285;
   localparam logic [9:0] F10_FISPOS  = 10'h283;
   localparam logic [9:0] F10_FLESS   = 10'h281;
   localparam logic [9:0] F10_FLOOR   = 10'h301;
   localparam logic [9:0] F10_FTOI    = 10'h300;
   localparam logic [9:0] F10_ITOF    = 10'h340;

   typedef struct packed {
      logic [IMM_W-1:0] imm;
      logic [REG_W-1:0] rs2;
      logic [REG_W-1:0] rs1;
      logic [REG_W-1:0] rd;
      logic [OP_W-1:0]  op;
      logic             valid_res;
   } decode_type;

   function automatic decode_type decode(input logic [INSTR_W-1:0] w);
      decode_type       res;
      logic [9:0]       f10;
      logic [2:0]       f3;
      logic [IMM_W-1:0] imm_i;
      logic [IMM_W-1:0] imm_s;
      logic             ok;
      logic             unary;
      logic             use_rd;
      logic             use_rs1;
      logic             use_rs2;
      logic [OP_W-1:0]  code;
      logic [IMM_W-1:0] imm;
      f3      = w[14:12];
      f10     = {w[31:25], w[14:12]};
      imm_i   = {{20{w[31]}}, w[31:20]};
      imm_s   = {{20{w[31]}}, w[31:25], w[11:7]};
      ok      = 1'b0;
      unary   = 1'b0;
      use_rd  = 1'b0;
      use_rs1 = 1'b0;
      use_rs2 = 1'b0;
      code    = OP_BEQ;
      imm     = '0;
      case (w[6:0])
         OPC_BRANCH: begin
            use_rs1 = 1'b1;
            use_rs2 = 1'b1;
            imm     = imm_s;
            ok      = 1'b1;
            case (f3)
               F3_BEQ: code = OP_BEQ;
               F3_BNE: code = OP_BNE;
               F3_BLT: code = OP_BLT;
               F3_BGE: code = OP_BGE;
               default: ok = 1'b0;
            endcase
         end
         OPC_LOAD: begin
            ok      = (f3 == F3_WORD);
            code    = OP_LW;
            use_rd  = 1'b1;
            use_rs1 = 1'b1;
            imm     = imm_i;
         end
         OPC_STORE: begin
            ok      = (f3 == F3_WORD);
            code    = OP_SW;
            use_rs1 = 1'b1;
            use_rs2 = 1'b1;
            imm     = imm_s;
         end
         OPC_ALUI: begin
            use_rd  = 1'b1;
            use_rs1 = 1'b1;
            imm     = imm_i;
            ok      = 1'b1;
            case (f3)
               F3_ADDI: code = OP_ADDI;
               F3_SLLI: code = OP_SLLI;
               F3_SRLI: code = OP_SRLI;
               default: ok = 1'b0;
            endcase
         end
         OPC_ALUR: begin
            use_rd  = 1'b1;
            use_rs1 = 1'b1;
            use_rs2 = 1'b1;
            ok      = 1'b1;
            case (f10)
               F10_ADD: code = OP_ADD;
               F10_SUB: code = OP_SUB;
               F10_SLL: code = OP_SLL;
               default: ok = 1'b0;
            endcase
         end
         OPC_LUI: begin
            ok     = 1'b1;
            code   = OP_LUI;
            use_rd = 1'b1;
            imm    = {w[31:12], 12'd0};
         end
         OPC_JAL: begin
            ok     = 1'b1;
            code   = OP_JAL;
            use_rd = 1'b1;
            imm    = {{12{w[31]}}, w[31:12]};
         end
         OPC_JALR: begin
            ok      = (f3 == F3_JALR);
            code    = OP_JALR;
            use_rd  = 1'b1;
            use_rs1 = 1'b1;
            imm     = imm_i;
         end
         OPC_FLOAT: begin
            ok    = 1'b1;
            unary = 1'b1;
            case (f10)
               F10_FADD: begin
                  code  = OP_FADD;
                  unary = 1'b0;
               end
               F10_FSUB: begin
                  code  = OP_FSUB;
                  unary = 1'b0;
               end
               F10_FMUL: begin
                  code  = OP_FMUL;
                  unary = 1'b0;
               end
               F10_FDIV: begin
                  code  = OP_FDIV;
                  unary = 1'b0;
               end
               F10_FHALF:   code = OP_FHALF;
               F10_SQRT:    code = OP_SQRT;
               F10_FABS:    code = OP_FABS;
               F10_FNEG:    code = OP_FNEG;
               F10_FISZERO: code = OP_FISZERO;
               F10_FISNEG:  code = OP_FISNEG;
               F10_FISPOS:  code = OP_FISPOS;
               F10_FLESS: begin
                  code  = OP_FLESS;
                  unary = 1'b0;
               end
               F10_FLOOR: code = OP_FLOOR;
               F10_FTOI:  code = OP_FTOI;
               F10_ITOF:  code = OP_ITOF;
               default:   ok = 1'b0;
            endcase
            // unary ops need the rs2 field clear
            if (unary && (w[24:20] != 5'd0)) begin
               ok = 1'b0;
            end
            use_rd  = 1'b1;
            use_rs1 = 1'b1;
            use_rs2 = !unary;
         end
         OPC_NOP: begin
            ok   = 1'b1;
            code = OP_NOP;
         end
         default: ok = 1'b0;
      endcase
      res.valid_res = ok;
      res.op        = ok ? code : OP_BEQ;
      res.rd        = (ok && use_rd) ? w[11:7] : '0;
      res.rs1       = (ok && use_rs1) ? w[19:15] : '0;
      res.rs2       = (ok && use_rs2) ? w[24:20] : '0;
      res.imm       = ok ? imm : '0;
      return res;
   endfunction

endpackage

[rtl/custom_rv32_instruction_decoder_unit.sv]
// path from req beat to rsp beat: input register, then result register
// throughput: one beat per cycle while rsp_tready is high, a new word is taken while the result register drains
// decode is single-pass logic between the two registers
// reset: synchronous, active high; clears both stage valids, payload is not reset
module custom_rv32_instruction_decoder_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rvdec_pkg::INSTR_W-1:0]     req_tdata,  // instruction[31:0]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // valid_res[0], op[5:1], rd[10:6], rs1[15:11], rs2[20:16], imm[52:21], zero[55:53]
   output logic [rvdec_pkg::RSP_W-1:0]       rsp_tdata
);

   logic                              in_valid_ff;
   logic                              in_valid_in;
   logic [rvdec_pkg::INSTR_W-1:0]     in_word_ff;
   logic                              out_valid_ff;
   logic                              out_valid_in;
   rvdec_pkg::decode_type             out_res_ff;
   rvdec_pkg::decode_type             dec;
   logic                              out_load;
   logic                              req_accept;

   assign out_load   = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || out_load;
   assign req_accept = req_tvalid && req_tready;
   assign dec        = rvdec_pkg::decode(in_word_ff);

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (out_load) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_load ? in_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_word_ff <= req_tdata;
      end
      if (out_load) begin
         out_res_ff <= dec;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(rvdec_pkg::RSP_W - $bits(rvdec_pkg::decode_type)){1'b0}},
                        out_res_ff};

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_res_ff.valid_res) |->
         (out_res_ff.op == '0 && out_res_ff.rd == '0 && out_res_ff.rs1 == '0 &&
          out_res_ff.rs2 == '0 && out_res_ff.imm == '0))
      else $error("invalid decode carries nonzero fields");

   a_op_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_res_ff.op <= rvdec_pkg::OP_NOP))
      else $error("op code out of range");

   a_nop_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_res_ff.op == rvdec_pkg::OP_NOP) |->
         (out_res_ff.rd == '0 && out_res_ff.rs1 == '0 && out_res_ff.rs2 == '0 &&
          out_res_ff.imm == '0))
      else $error("nop with nonzero fields");

   a_accept_holds: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> in_valid_ff)
      else $error("accepted beat lost in input stage");

endmodule
